// ===== sv/ps2_scancode_to_ascii_assert.svh =====
// assertion macros for the ps2 scan code decoder
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef PS2_SCANCODE_TO_ASCII_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define PS2SC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ps2sc assertion failed");

// antecedent in one cycle implies consequent in the next
`define PS2SC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2sc assertion failed");

`else

`define PS2SC_ASSERT(lbl, cond)
`define PS2SC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/ps2sc_pkg.sv =====
// shared constants, types and key tables for the ps2 scan code decoder
// no dependencies
`timescale 1ns / 1ps

package ps2sc_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_UP      = 7'h48;
  localparam logic [6:0] KEY_DOWN    = 7'h50;
  localparam logic [6:0] KEY_LEFT    = 7'h4B;
  localparam logic [6:0] KEY_RIGHT   = 7'h4D;
  localparam logic [6:0] CODE_UP     = 7'h10;
  localparam logic [6:0] CODE_DOWN   = 7'h0E;
  localparam logic [6:0] CODE_LEFT   = 7'h02;
  localparam logic [6:0] CODE_RIGHT  = 7'h06;
  localparam logic [6:0] MAP_LAST    = 7'h3A;

  typedef struct packed {
    logic       valid;
    logic [7:0] scan_byte;
  } ps2sc_item_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] character;
  } ps2sc_res_t;

  localparam logic [6:0] PLAIN_MAP [0:58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] UPPER_MAP [0:58] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  // keys above the table give zero
  function automatic logic [6:0] key_to_ascii(input logic shift, input logic [6:0] key);
    logic [6:0] r;
    r = 7'h00;
    if (key <= MAP_LAST) begin
      r = shift ? UPPER_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
    end
    return r;
  endfunction

endpackage

// ===== sv/ps2sc_if.sv =====
// handshake channels for the ps2 scan code decoder: scan bytes in, characters out
// no dependencies
`timescale 1ns / 1ps

interface ps2sc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2sc_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// ===== sv/ps2_scancode_to_ascii.sv =====
// top level of the ps2 scan code set 1 to ascii decoder
// uses ps2sc_pkg, ps2sc_if, ps2sc_in_stage, ps2sc_decode, ps2sc_out_stage
//
//   channel  | dir | payload          | transaction
//   byte_i   | in  | scan_byte[7:0]   | one raw set 1 scan code byte
//   char_o   | out | character[6:0]   | one ascii character or arrow code
//
// one byte per cycle while no character is held back by a full result register; a
// byte passes the input register, then its character the result register to char_o
// input register, decode and state update, then result register
// bytes that give no character pass without touching the result register
// a stalled result only holds back a byte that itself gives a character
// reset clears shift and prefix state and empties both registers
`timescale 1ns / 1ps

module ps2_scancode_to_ascii
  import ps2sc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2sc_byte_if.sink   byte_i,
  ps2sc_char_if.source char_o
);

  ps2sc_item_t item;
  ps2sc_res_t  res;
  logic        out_free;
  logic        advance;

  assign advance = item.valid && (!res.valid || out_free);

  ps2sc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .item_o    (item)
  );

  ps2sc_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .take_i (advance),
    .res_o  (res)
  );

  ps2sc_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .load_i (advance && res.valid),
    .free_o (out_free),
    .char_o (char_o)
  );

endmodule

// ===== sv/ps2sc_in_stage.sv =====
// input register of the ps2 scan code decoder
// uses ps2sc_pkg and ps2sc_byte_if
`timescale 1ns / 1ps

module ps2sc_in_stage
  import ps2sc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ps2sc_byte_if.sink       byte_i,
  input  logic             advance_i,
  output ps2sc_item_t      item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // a slot frees up in the same cycle its byte is decoded
  assign byte_i.ready = !valid_q || advance_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i.scan_byte;
    end
  end

  assign item_o.valid     = valid_q;
  assign item_o.scan_byte = byte_q;

endmodule

// ===== sv/ps2sc_decode.sv =====
// key state and scan code decode for the ps2 scan code decoder
// uses ps2sc_pkg and the assertion macros
`timescale 1ns / 1ps
`include "ps2_scancode_to_ascii_assert.svh"

module ps2sc_decode
  import ps2sc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ps2sc_item_t item_i,
  input  logic        take_i,
  output ps2sc_res_t  res_o
);

  logic       shift_q, shift_d;
  logic       ext_q, ext_d;
  logic       brk;
  logic [6:0] key;
  logic       is_shift;
  logic [6:0] lut;
  logic       hit;
  logic [6:0] ch;

  assign brk      = item_i.scan_byte[7];
  assign key      = item_i.scan_byte[6:0];
  assign is_shift = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
  assign lut      = key_to_ascii(shift_q, key);

  always_comb begin
    shift_d = shift_q;
    ext_d   = ext_q;
    hit     = 1'b0;
    ch      = lut;
    if (item_i.scan_byte == PREFIX_BYTE) begin
      ext_d = 1'b1;
    end else if (is_shift) begin
      shift_d = !brk;
      ext_d   = 1'b0;
    end else if (brk) begin
      ext_d = 1'b0;
    end else if (ext_q) begin
      ext_d = 1'b0;
      hit   = 1'b1;
      case (key)
        KEY_UP:    ch = CODE_UP;
        KEY_DOWN:  ch = CODE_DOWN;
        KEY_LEFT:  ch = CODE_LEFT;
        KEY_RIGHT: ch = CODE_RIGHT;
        default:   hit = 1'b0;
      endcase
    end else begin
      hit = (lut != 7'h00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ext_q   <= 1'b0;
    end else if (take_i) begin
      shift_q <= shift_d;
      ext_q   <= ext_d;
    end
  end

  assign res_o.valid     = item_i.valid && hit;
  assign res_o.character = ch;

  `PS2SC_ASSERT_NEXT(a_prefix_sets_ext, take_i && item_i.scan_byte == PREFIX_BYTE, ext_q)
  `PS2SC_ASSERT_NEXT(a_other_clears_ext, take_i && item_i.scan_byte != PREFIX_BYTE, !ext_q)
  `PS2SC_ASSERT_NEXT(a_shift_make, take_i && !brk && is_shift, shift_q)
  `PS2SC_ASSERT(a_no_nul_char, !res_o.valid || res_o.character != 7'h00)

endmodule

// ===== sv/ps2sc_out_stage.sv =====
// result register of the ps2 scan code decoder
// uses ps2sc_pkg and ps2sc_char_if
`timescale 1ns / 1ps

module ps2sc_out_stage
  import ps2sc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ps2sc_res_t   res_i,
  input  logic         load_i,
  output logic         free_o,
  ps2sc_char_if.source char_o
);

  logic       full_q, full_d;
  logic [6:0] char_q;

  // register can take a new character when empty or being drained this cycle
  assign free_o = !full_q || char_o.ready;

  always_comb begin
    full_d = full_q;
    if (load_i) begin
      full_d = 1'b1;
    end else if (char_o.ready) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= res_i.character;
    end
  end

  assign char_o.valid     = full_q;
  assign char_o.character = char_q;

endmodule

// ===== test/ps2_scancode_to_ascii_test.sv =====
// testbench for the ps2 scan code set 1 to ascii decoder: directed and random scan bytes,
// characters checked in order against a predictor; uses ps2sc_pkg and ps2sc_if
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_test;
  import ps2sc_pkg::*;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  // key number to character, without and with shift
  localparam logic [6:0] KEYMAP_BARE [0:58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] KEYMAP_SHIFTED [0:58] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ps2sc_byte_if byte_if ();
  ps2sc_char_if char_if ();

  ps2_scancode_to_ascii dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .char_o (char_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic       shift_down;
  logic       prefix_seen;
  logic [6:0] expected_chars [$];

  int       failures;
  int       bytes_sent;
  int       burst_left;
  int       max_gap;
  int       hold_len;
  int       rx_cycle;
  rx_mode_e rx_mode;
  logic [6:0] want_char;

  function automatic void decode_scan(input logic [7:0] code, output logic hit,
                                      output logic [6:0] ch);
    logic [6:0] key;
    logic       brk;
    key = code[6:0];
    brk = code[7];
    hit = 1'b0;
    ch  = 7'h00;
    if (code == PREFIX_BYTE) begin
      prefix_seen = 1'b1;
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      shift_down  = !brk;
      prefix_seen = 1'b0;
    end else if (brk) begin
      prefix_seen = 1'b0;
    end else if (prefix_seen) begin
      prefix_seen = 1'b0;
      hit = 1'b1;
      case (key)
        KEY_UP:    ch = CODE_UP;
        KEY_DOWN:  ch = CODE_DOWN;
        KEY_LEFT:  ch = CODE_LEFT;
        KEY_RIGHT: ch = CODE_RIGHT;
        default:   hit = 1'b0;
      endcase
    end else if (key <= MAP_LAST) begin
      ch  = shift_down ? KEYMAP_SHIFTED[key[5:0]] : KEYMAP_BARE[key[5:0]];
      hit = (ch != 7'h00);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [6:0] want,
                                 input logic [6:0] got);
    failures++;
    if (failures <= 10) begin
      $display("mismatch %0s: expected %02h, got %02h", what, want, got);
    end
  endtask

  // one scan byte transaction, then a random gap at the end of a burst
  task automatic send_scan(input logic [7:0] code);
    logic       hit;
    logic [6:0] ch;
    int         gap;
    byte_if.valid     <= 1'b1;
    byte_if.scan_byte <= code;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    decode_scan(code, hit, ch);
    if (hit) expected_chars.push_back(ch);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly real keyboard traffic, some raw noise
  task automatic send_key_event();
    logic [6:0] key;
    int         kind;
    kind = $urandom_range(0, 15);
    if (kind <= 5) begin
      key = 7'($urandom_range(0, MAP_LAST));
      send_scan({1'b0, key});
      if ($urandom_range(0, 1)) send_scan({1'b1, key});
    end else if (kind <= 7) begin
      key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
      send_scan({1'($urandom_range(0, 1)), key});
    end else if (kind <= 9) begin
      case ($urandom_range(0, 3))
        0:       key = KEY_UP;
        1:       key = KEY_DOWN;
        2:       key = KEY_LEFT;
        default: key = KEY_RIGHT;
      endcase
      send_scan(PREFIX_BYTE);
      send_scan({1'b0, key});
      if ($urandom_range(0, 1)) begin
        send_scan(PREFIX_BYTE);
        send_scan({1'b1, key});
      end
    end else if (kind <= 11) begin
      send_scan(PREFIX_BYTE);
      send_scan(8'($urandom_range(0, 255)));
    end else begin
      send_scan(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_plain_keys();
    rx_mode = RX_ALWAYS;
    max_gap = 3;
    send_scan(8'h00);
    send_scan(8'h01);
    send_scan(8'h39);
    send_scan(8'h3A);
    send_scan(8'h7F);
    wait_idle();
  endtask

  task automatic test_shift_keys();
    rx_mode = RX_COIN;
    send_scan({1'b0, KEY_LSHIFT});
    send_scan(8'h1E);
    send_scan({1'b1, KEY_LSHIFT});
    // shift behind a prefix still counts as shift
    send_scan(PREFIX_BYTE);
    send_scan({1'b0, KEY_RSHIFT});
    send_scan(8'h0D);
    send_scan(PREFIX_BYTE);
    send_scan({1'b1, KEY_RSHIFT});
    wait_idle();
  endtask

  task automatic test_extended_keys();
    rx_mode = RX_PATTERN;
    send_scan(PREFIX_BYTE);
    send_scan({1'b0, KEY_UP});
    send_scan(PREFIX_BYTE);
    send_scan(PREFIX_BYTE);
    send_scan({1'b0, KEY_DOWN});
    send_scan(PREFIX_BYTE);
    send_scan({1'b0, KEY_LEFT});
    send_scan(PREFIX_BYTE);
    send_scan({1'b0, KEY_RIGHT});
    // non-arrow extended make is dropped, break clears the prefix
    send_scan(PREFIX_BYTE);
    send_scan(8'h1C);
    send_scan(PREFIX_BYTE);
    send_scan({1'b1, KEY_UP});
    send_scan(8'hFF);
    wait_idle();
  endtask

  task automatic test_pressure();
    rx_mode  = RX_ALWAYS;
    max_gap  = 0;
    hold_len = 400;
    repeat (120) send_scan(8'($urandom_range(16, 25)));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count, input rx_mode_e mode, input int gap_max);
    int stop_at;
    rx_mode = mode;
    max_gap = gap_max;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_key_event();
    wait_idle();
  endtask

  // receiver ready pattern, with an optional long hold-off
  initial begin
    char_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_len > 0) begin
        hold_len--;
        char_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  char_if.ready <= 1'b1;
          RX_COIN:    char_if.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: char_if.ready <= ((rx_cycle % 11) > 3);
          default:    char_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", 7'h00, char_if.character);
      end else begin
        want_char = expected_chars.pop_front();
        if (char_if.character !== want_char) begin
          report_mismatch("character", want_char, char_if.character);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("ps2_scancode_to_ascii_test NOT OK");
    $finish;
  end

  initial begin
    failures    = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    max_gap     = 0;
    hold_len    = 0;
    rx_cycle    = 0;
    rx_mode     = RX_ALWAYS;
    shift_down  = 1'b0;
    prefix_seen = 1'b0;
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.scan_byte <= 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_keys();
    test_shift_keys();
    test_extended_keys();
    test_pressure();
    test_random_traffic(320, RX_ALWAYS, 0);
    test_random_traffic(320, RX_COIN, 6);
    test_random_traffic(320, RX_PATTERN, 3);
    test_random_traffic(320, RX_SPARSE, 8);

    repeat (20) @(posedge clk_i);
    if (failures == 0 && expected_chars.size() == 0) begin
      $display("ps2_scancode_to_ascii_test OK");
    end else begin
      $display("ps2_scancode_to_ascii_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== ps2_scancode_to_ascii.f =====
+incdir+sv
sv/ps2sc_pkg.sv
sv/ps2sc_if.sv
sv/ps2sc_in_stage.sv
sv/ps2sc_decode.sv
sv/ps2sc_out_stage.sv
sv/ps2_scancode_to_ascii.sv
test/ps2_scancode_to_ascii_test.sv
